>>> rtl/assert_macros.svh
// Assertion macros included by the cipher top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication that must hold at every clock edge outside reset.
`define ASSERT_IMPL(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Implication checked at every edge, also during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

>>> rtl/sfbc_pkg.sv
// Package with payload types and constants of the SHA-256 Feistel cipher.
package sfbc_pkg;

  typedef struct packed {
    logic [63:0] in_w0;
    logic [63:0] in_w1;
    logic [63:0] in_w2;
    logic [63:0] in_w3;
    logic        encrypt;
  } sfbc_in_t;

  typedef struct packed {
    logic [63:0] out_w0;
    logic [63:0] out_w1;
    logic [63:0] out_w2;
    logic [63:0] out_w3;
  } sfbc_out_t;

  // Register addresses (64-bit registers at 8*i).
  localparam logic [2:0] RegKey0    = 3'd0;
  localparam logic [2:0] RegKey1    = 3'd1;
  localparam logic [2:0] RegKey2    = 3'd2;
  localparam logic [2:0] RegKey3    = 3'd3;
  localparam logic [2:0] RegKeyBits = 3'd4;
  localparam logic [2:0] RegRounds  = 3'd5;

  localparam logic [8:0] KeyBitsReset = 9'd256;
  localparam logic [6:0] RoundsReset  = 7'd16;

  localparam logic [255:0] HashInit = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  // SHA-256 round constants.
  function automatic logic [31:0] round_const(input logic [5:0] idx);
    logic [31:0] k;
    case (idx)
      6'd0: k = 32'h428a2f98;   6'd1: k = 32'h71374491;
      6'd2: k = 32'hb5c0fbcf;   6'd3: k = 32'he9b5dba5;
      6'd4: k = 32'h3956c25b;   6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4;   6'd7: k = 32'hab1c5ed5;
      6'd8: k = 32'hd807aa98;   6'd9: k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

endpackage

>>> rtl/sha256_feistel_block_cipher_unit.sv
// Top level of the SHA-256 Feistel block cipher with its register port.
//
// Channel   Direction  Handshake            Payload
// block in  input      start_i & !busy_o    in_i (sfbc_in_t)
// result    output     done_o, one cycle    out_o (sfbc_out_t)
// config    input      APB write            pwdata, 64 bits at 8*i
//
// Each item passes through its Feistel rounds in order: per round, a load step,
// 64 compression steps on the single shared SHA-256 step unit, and a digest
// add with a half swap (no swap in the last round). With zero rounds the input
// is passed to out_o unchanged. A new item is taken in the done_o cycle.
// Reset clears control state and sets registers to their reset values.
// busy_o stays high from acceptance until the cycle of done_o (not at all for zero rounds); the
// receiver cannot stall and takes the result in the done_o cycle.
`include "assert_macros.svh"
module sha256_feistel_block_cipher_unit #(
  parameter int unsigned MAX_KEY_BITS = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  sfbc_pkg::sfbc_in_t  in_i,
  output logic                busy_o,
  output logic                done_o,
  output sfbc_pkg::sfbc_out_t out_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [5:0]          paddr,
  input  logic [63:0]         pwdata,
  output logic [63:0]         prdata,
  output logic                pready
);
  import sfbc_pkg::*;

  typedef enum logic [1:0] {StIdle, StLoad, StComp, StFin} state_e;

  localparam logic [8:0] MaxKb = 9'(MAX_KEY_BITS);

  // Configuration registers.
  logic [255:0] key_q;
  logic [8:0]   kbits_q;
  logic [6:0]   rounds_q;
  logic         wr_en;
  logic [2:0]   reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q    <= '0;
      kbits_q  <= KeyBitsReset;
      rounds_q <= RoundsReset;
    end else if (wr_en) begin
      case (reg_idx)
        RegKey0:    key_q[255:192] <= pwdata;
        RegKey1:    key_q[191:128] <= pwdata;
        RegKey2:    key_q[127:64]  <= pwdata;
        RegKey3:    key_q[63:0]    <= pwdata;
        RegKeyBits: kbits_q  <= pwdata[8:0];
        RegRounds:  rounds_q <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  // Register read mux.
  always_comb begin
    case (reg_idx)
      RegKey0:    prdata = key_q[255:192];
      RegKey1:    prdata = key_q[191:128];
      RegKey2:    prdata = key_q[127:64];
      RegKey3:    prdata = key_q[63:0];
      RegKeyBits: prdata = {55'd0, kbits_q};
      RegRounds:  prdata = {57'd0, rounds_q};
      default:    prdata = '0;
    endcase
  end

  // Round message tail: key bits masked, pad bit, length. Computed combinationally
  // from the saturated key length; depends only on configuration.
  logic [8:0]   kb;
  logic [9:0]   total;
  logic [367:0] tail;     // message bits 144..511 (the key area and length)
  logic [367:0] keymask;
  logic [367:0] padbit;

  assign kb    = (kbits_q > MaxKb) ? MaxKb : kbits_q;
  assign total = 10'd144 + {1'b0, kb};

  always_comb begin
    keymask = ~({368{1'b1}} >> kb);
    padbit  = {1'b1, 367'd0} >> kb;
    tail    = (({key_q, 112'd0}) & keymask) | padbit;
    tail[15:0] = tail[15:0] | {6'd0, total};
  end

  // Datapath state.
  state_e       state_q;
  logic [127:0] left_q, right_q;
  logic [6:0]   step_q, ridx_q;
  logic         enc_q;
  logic [5:0]   t_q;
  logic [511:0] w_q;     // 16-word schedule window, word t at the top
  logic [255:0] a_q;     // working variables a..h, a at the top

  // Shared compression step: one SHA-256 round per cycle while in the compression state.
  logic [31:0] va, vb, vc, vd, ve, vf, vg, vh, wt, t1, t2, s0, s1, wn;
  logic [31:0] w1, w9, w14;
  assign {va, vb, vc, vd, ve, vf, vg, vh} = a_q;
  assign wt  = w_q[511:480];
  assign w1  = w_q[479:448];
  assign w9  = w_q[223:192];
  assign w14 = w_q[63:32];
  assign t1 = vh + ({ve[5:0], ve[31:6]} ^ {ve[10:0], ve[31:11]} ^ {ve[24:0], ve[31:25]})
            + ((ve & vf) ^ (~ve & vg)) + round_const(t_q) + wt;
  assign t2 = ({va[1:0], va[31:2]} ^ {va[12:0], va[31:13]} ^ {va[21:0], va[31:22]})
            + ((va & vb) ^ (va & vc) ^ (vb & vc));
  assign s0 = {w1[6:0], w1[31:7]} ^ {w1[17:0], w1[31:18]} ^ (w1 >> 3);
  assign s1 = {w14[16:0], w14[31:17]} ^ {w14[18:0], w14[31:19]} ^ (w14 >> 10);
  assign wn = wt + s0 + w9 + s1;

  // Digest words 0..3 added to the initial hash.
  logic [127:0] digest;
  assign digest = {a_q[255:224] + HashInit[255:224], a_q[223:192] + HashInit[223:192],
                   a_q[191:160] + HashInit[191:160], a_q[159:128] + HashInit[159:128]};

  logic last_round;
  assign last_round = (step_q + 7'd1 == rounds_q);

  // Sequencer and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      done_o  <= 1'b0;
      step_q  <= '0;
      t_q     <= '0;
    end else begin
      done_o <= 1'b0;
      case (state_q)
        StIdle: begin
          if (start_i) begin
            left_q  <= {in_i.in_w0, in_i.in_w1};
            right_q <= {in_i.in_w2, in_i.in_w3};
            enc_q   <= in_i.encrypt;
            step_q  <= '0;
            if (rounds_q == 7'd0) begin
              out_o   <= {in_i.in_w0, in_i.in_w1, in_i.in_w2, in_i.in_w3};
              done_o  <= 1'b1;
            end else begin
              ridx_q  <= in_i.encrypt ? 7'd0 : rounds_q - 7'd1;
              state_q <= StLoad;
            end
          end
        end
        StLoad: begin
          w_q     <= {right_q, 8'd0, 1'b0, ridx_q, tail};
          a_q     <= HashInit;
          t_q     <= '0;
          state_q <= StComp;
        end
        StComp: begin
          a_q <= {t1 + t2, va, vb, vc, vd + t1, ve, vf, vg};
          // The word 16 places ahead enters at the bottom of the window.
          w_q <= {w_q[479:0], wn};
          t_q <= t_q + 6'd1;
          if (t_q == 6'd63) state_q <= StFin;
        end
        StFin: begin
          if (last_round) begin
            out_o   <= {left_q ^ digest, right_q};
            done_o  <= 1'b1;
            state_q <= StIdle;
          end else begin
            left_q  <= right_q;
            right_q <= left_q ^ digest;
            step_q  <= step_q + 7'd1;
            ridx_q  <= enc_q ? ridx_q + 7'd1 : ridx_q - 7'd1;
            state_q <= StLoad;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign busy_o = (state_q != StIdle);

  // Checks on sequencing.
  `ASSERT_IMPL(a_done_idle, clk_i, rst_ni, done_o |-> !busy_o, "done while busy")
  `ASSERT_IMPL(a_step_range, clk_i, rst_ni, busy_o |-> (step_q < rounds_q), "step overrun")
  `ASSERT_IMPL(a_fin_after_comp, clk_i, rst_ni, (state_q == StFin) |-> $past(t_q) == 6'd63,
    "finish without full compression")
endmodule
